@@ rtl/bsc_pkg.sv @@
`default_nettype none
package bsc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CAL_A   = 2'd0,
    REG_CAL_B   = 2'd1,
    REG_CAL_C   = 2'd2,
    REG_OSS     = 2'd3
  } bsc_reg_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } bsc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic               divide_error;
  } bsc_out_t;

  // one pipeline stage worth of working values
  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
    logic [31:0] x1t;
    logic [31:0] acc;
    logic [31:0] tval;
    logic [31:0] m0;
    logic [31:0] m1;
    logic [31:0] m2;
    logic [31:0] m3;
    logic [31:0] m4;
    logic [31:0] dvd;
    logic [31:0] rem;
    logic [31:0] dvs;
    logic        qneg;
    logic        dbl;
    logic        err;
  } bsc_pipe_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] dvd;
  } bsc_div_t;

  localparam int DIV_BITS      = 32;
  localparam int DIV_STEPS     = 2;
  localparam int DIV_STAGES    = DIV_BITS / DIV_STEPS;

  localparam int ST_IN         = 0;
  localparam int ST_X1         = 1;
  localparam int ST_DIV1_SET   = 2;
  localparam int ST_DIV1_FIRST = 3;
  localparam int ST_DIV1_LAST  = ST_DIV1_FIRST + DIV_STAGES - 1;
  localparam int ST_B5         = ST_DIV1_LAST + 1;
  localparam int ST_B6         = ST_B5 + 1;
  localparam int ST_MUL_B6     = ST_B6 + 1;
  localparam int ST_SQ         = ST_MUL_B6 + 1;
  localparam int ST_MUL_SQ     = ST_SQ + 1;
  localparam int ST_X3         = ST_MUL_SQ + 1;
  localparam int ST_B3         = ST_X3 + 1;
  localparam int ST_B4         = ST_B3 + 1;
  localparam int ST_B7         = ST_B4 + 1;
  localparam int ST_DIV2_SET   = ST_B7 + 1;
  localparam int ST_DIV2_FIRST = ST_DIV2_SET + 1;
  localparam int ST_DIV2_LAST  = ST_DIV2_FIRST + DIV_STAGES - 1;
  localparam int ST_P          = ST_DIV2_LAST + 1;
  localparam int ST_PD         = ST_P + 1;
  localparam int ST_PSQ        = ST_PD + 1;
  localparam int ST_PK         = ST_PSQ + 1;
  localparam int ST_PKD        = ST_PK + 1;
  localparam int ST_OUT        = ST_PKD + 1;
  localparam int STAGES        = ST_OUT + 1;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] B7_SCALE   = 32'd50000;
  localparam logic [31:0] X3_OFFSET  = 32'd32768;
  localparam logic [31:0] P_K1       = 32'd3038;
  localparam logic [31:0] P_K2       = 32'hFFFF_E343; // -7357
  localparam logic [31:0] P_K3       = 32'd3791;

  // signed divide by 2**k, truncating toward zero
  function automatic logic [31:0] sdiv_p2(logic [31:0] a, int unsigned k);
    logic [31:0] bias;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    return 32'($signed(a + bias) >>> k);
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] a);
    return a[31] ? (32'd0 - a) : a;
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] a);
    return {{16{a[15]}}, a};
  endfunction

  // one restoring division step
  function automatic bsc_div_t div_step(bsc_div_t s, logic [31:0] d);
    logic [32:0] t;
    bsc_div_t    r;
    t = {s.rem, s.dvd[31]};
    if (t >= {1'b0, d}) begin
      r.rem = 32'(t - {1'b0, d});
      r.dvd = {s.dvd[30:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.dvd = {s.dvd[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/baro_sensor_compensation.sv @@
// channel  dir  handshake               payload
// in_      in   in_valid / in_ready     in_data   (bsc_in_t)
// out_     out  out_valid / out_ready   out_data  (bsc_out_t)
// cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// 51 register stages: one beat enters per cycle while out_ is not stalled, and its
// result is on out_ once the beat reaches the last stage, ST_OUT
// the two 32-bit dividers are 16 stages each at 2 quotient bits per stage
// rst_n is synchronous; it clears stage valid bits and configuration
// each stage moves whenever the one after it is empty or moving, so bubbles
// close up under an output stall and nothing is dropped or repeated
`default_nettype none
module baro_sensor_compensation import bsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire bsc_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output bsc_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // calibration registers
  logic [63:0] cal_a_r;
  logic [63:0] cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bsc_reg_t'(cfg_index))
        REG_CAL_A: cal_a_r <= cfg_data;
        REG_CAL_B: cal_b_r <= cfg_data;
        REG_CAL_C: cal_c_r <= cfg_data[31:0];
        REG_OSS:   oss_r   <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  // coefficients, sign- or zero-extended to the 32-bit datapath
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sext16(cal_a_r[63:48]);
  assign ac2 = sext16(cal_a_r[47:32]);
  assign ac3 = sext16(cal_a_r[31:16]);
  assign ac4 = {16'd0, cal_a_r[15:0]};
  assign ac5 = {16'd0, cal_b_r[63:48]};
  assign ac6 = {16'd0, cal_b_r[47:32]};
  assign b1  = sext16(cal_b_r[31:16]);
  assign b2  = sext16(cal_b_r[15:0]);
  assign mc  = sext16(cal_c_r[31:16]);
  assign md  = sext16(cal_c_r[15:0]);

  bsc_pipe_t          pipe_r   [STAGES];
  bsc_pipe_t          pipe_nxt [STAGES];
  logic [STAGES-1:0]  valid_r;
  logic [STAGES-1:0]  adv;

  // a stage may load when it is empty or its beat moves on
  always_comb begin
    adv[STAGES-1] = !valid_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_ready = adv[ST_IN];

  always_comb begin
    bsc_div_t d;
    d = '0;
    pipe_nxt[ST_IN]     = '0;
    pipe_nxt[ST_IN].ut  = in_data.raw_temperature;
    pipe_nxt[ST_IN].up  = in_data.raw_pressure;
    for (int k = 1; k < STAGES; k++) begin
      pipe_nxt[k] = pipe_r[k-1];
      if (k == ST_X1) begin
        // x1 = ((ut - ac6) * ac5) >> 15, den = x1 + md
        pipe_nxt[k].x1t =
          32'($signed(({16'd0, pipe_r[k-1].ut} - ac6) * ac5) >>> 15);
        pipe_nxt[k].acc = 32'($signed(({16'd0, pipe_r[k-1].ut} - ac6) * ac5) >>> 15) + md;
      end else if (k == ST_DIV1_SET) begin
        pipe_nxt[k].err  = (pipe_r[k-1].acc == 32'd0);
        pipe_nxt[k].qneg = mc[31] ^ pipe_r[k-1].acc[31];
        pipe_nxt[k].dvs  = abs32(pipe_r[k-1].acc);
        pipe_nxt[k].dvd  = abs32(mc << 11);
        pipe_nxt[k].rem  = '0;
      end else if ((k >= ST_DIV1_FIRST && k <= ST_DIV1_LAST) ||
                   (k >= ST_DIV2_FIRST && k <= ST_DIV2_LAST)) begin
        d.rem = pipe_r[k-1].rem;
        d.dvd = pipe_r[k-1].dvd;
        for (int s = 0; s < DIV_STEPS; s++) begin
          d = div_step(d, pipe_r[k-1].dvs);
        end
        pipe_nxt[k].rem = d.rem;
        pipe_nxt[k].dvd = d.dvd;
      end else if (k == ST_B5) begin
        pipe_nxt[k].acc = pipe_r[k-1].x1t +
          (pipe_r[k-1].qneg ? (32'd0 - pipe_r[k-1].dvd) : pipe_r[k-1].dvd);
      end else if (k == ST_B6) begin
        pipe_nxt[k].tval = sdiv_p2(pipe_r[k-1].acc + 32'd8, 4);
        pipe_nxt[k].acc  = pipe_r[k-1].acc - B6_OFFSET;
      end else if (k == ST_MUL_B6) begin
        pipe_nxt[k].m0 = pipe_r[k-1].acc * pipe_r[k-1].acc;
        pipe_nxt[k].m1 = ac2 * pipe_r[k-1].acc;
        pipe_nxt[k].m2 = ac3 * pipe_r[k-1].acc;
      end else if (k == ST_SQ) begin
        pipe_nxt[k].m0 = sdiv_p2(pipe_r[k-1].m0, 12);
        pipe_nxt[k].m1 = sdiv_p2(pipe_r[k-1].m1, 11);
        pipe_nxt[k].m2 = sdiv_p2(pipe_r[k-1].m2, 13);
      end else if (k == ST_MUL_SQ) begin
        pipe_nxt[k].m3 = b2 * pipe_r[k-1].m0;
        pipe_nxt[k].m4 = b1 * pipe_r[k-1].m0;
      end else if (k == ST_X3) begin
        pipe_nxt[k].m3 = sdiv_p2(pipe_r[k-1].m3, 11) + pipe_r[k-1].m1;
        pipe_nxt[k].m4 = pipe_r[k-1].m2 + sdiv_p2(pipe_r[k-1].m4, 16) + 32'd2;
      end else if (k == ST_B3) begin
        pipe_nxt[k].m3 = sdiv_p2((((ac1 << 2) + pipe_r[k-1].m3) << oss_r) + 32'd2, 2);
        pipe_nxt[k].m4 = sdiv_p2(pipe_r[k-1].m4, 2);
      end else if (k == ST_B4) begin
        // b4 is unsigned: logical shift
        pipe_nxt[k].dvs = (ac4 * (pipe_r[k-1].m4 + X3_OFFSET)) >> 15;
        pipe_nxt[k].m0  = {13'd0, pipe_r[k-1].up} - pipe_r[k-1].m3;
      end else if (k == ST_B7) begin
        pipe_nxt[k].m0  = pipe_r[k-1].m0 * (B7_SCALE >> oss_r);
        pipe_nxt[k].err = pipe_r[k-1].err || (pipe_r[k-1].dvs == 32'd0);
      end else if (k == ST_DIV2_SET) begin
        // below 2**31 the doubling goes before the divide, else after
        pipe_nxt[k].dbl = pipe_r[k-1].m0[31];
        pipe_nxt[k].dvd = pipe_r[k-1].m0[31] ? pipe_r[k-1].m0 : (pipe_r[k-1].m0 << 1);
        pipe_nxt[k].rem = '0;
      end else if (k == ST_P) begin
        pipe_nxt[k].m0 = pipe_r[k-1].dbl ? (pipe_r[k-1].dvd << 1) : pipe_r[k-1].dvd;
      end else if (k == ST_PD) begin
        pipe_nxt[k].m1 = sdiv_p2(pipe_r[k-1].m0, 8);
        pipe_nxt[k].m2 = P_K2 * pipe_r[k-1].m0;
      end else if (k == ST_PSQ) begin
        pipe_nxt[k].m1 = pipe_r[k-1].m1 * pipe_r[k-1].m1;
        pipe_nxt[k].m2 = sdiv_p2(pipe_r[k-1].m2, 16);
      end else if (k == ST_PK) begin
        pipe_nxt[k].m1 = pipe_r[k-1].m1 * P_K1;
      end else if (k == ST_PKD) begin
        pipe_nxt[k].m1 = sdiv_p2(pipe_r[k-1].m1, 16);
      end else if (k == ST_OUT) begin
        // results forced to zero on a zero divisor
        pipe_nxt[k].m0 = pipe_r[k-1].err ? 32'd0 : pipe_r[k-1].m0 +
          sdiv_p2(pipe_r[k-1].m1 + pipe_r[k-1].m2 + P_K3, 4);
        pipe_nxt[k].tval = pipe_r[k-1].err ? 32'd0 : pipe_r[k-1].tval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[ST_IN]) begin
        valid_r[ST_IN] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (adv[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  assign out_valid                   = valid_r[ST_OUT];
  assign out_data.temperature_tenths = $signed(pipe_r[ST_OUT].tval);
  assign out_data.pressure_pa        = $signed(pipe_r[ST_OUT].m0);
  assign out_data.divide_error       = pipe_r[ST_OUT].err;

  // a flagged beat carries zero results
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_error |->
      out_data.temperature_tenths == 32'sd0 && out_data.pressure_pa == 32'sd0)
    else $error("divide error beat with nonzero results");

  // an empty output stage lets the whole pipe move
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule
`default_nettype wire
